[src/wcts_pkg.sv]
// Shared types and constants for the weighted completion time scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wcts_pkg;

    localparam int MAX_JOBS  = 1024;
    localparam int ADDR_W    = $clog2(MAX_JOBS);
    localparam int COUNT_W   = ADDR_W + 1;
    localparam int DUR_W     = 16;
    localparam int WGT_W     = 16;
    localparam int COST_W    = 30;
    localparam int ELAPSED_W = DUR_W + ADDR_W;
    localparam int PROD_W    = ELAPSED_W + WGT_W;
    localparam int SHIFT_MAX = PROD_W - COST_W;
    localparam int SHIFT_W   = $clog2(SHIFT_MAX + 1);
    localparam logic [COST_W-1:0] COST_MOD = COST_W'(1000000007);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_MUL,
        ST_INS_CMP,
        ST_ACC_START,
        ST_ACC_CHK,
        ST_ACC_ADD,
        ST_ACC_MUL,
        ST_ACC_MOD,
        ST_ACC_SUM,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture an incoming job
        logic ins_place;  // write new job at insertion point, bump count
        logic ins_read;   // read entry just above insertion point
        logic ins_mul;    // form the two cross products
        logic ins_shift;  // move entry down one slot
        logic acc_clear;
        logic acc_read;
        logic acc_add;
        logic acc_mul;
        logic acc_mod;
        logic acc_sum;
        logic emit;       // load result register, clear batch
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic last;
        logic pos_zero;
        logic goes_first;
        logic acc_done;
        logic mod_last;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

[src/wcts_ctrl.sv]
// Controller state machine: sequences insertion on load, then the cost walk.
// Depends on wcts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wcts_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wcts_pkg::status_t     status,
    output wcts_pkg::cmd_t        cmd
);

    wcts_pkg::state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wcts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wcts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wcts_pkg::ST_INS_CHK;
                end
            end
            wcts_pkg::ST_INS_CHK:
            begin
                if (status.full)
                begin
                    state_next = status.last ? wcts_pkg::ST_ACC_START : wcts_pkg::ST_IDLE;
                end
                else if (status.pos_zero)
                begin
                    state_next = status.last ? wcts_pkg::ST_ACC_START : wcts_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = wcts_pkg::ST_INS_MUL;
                end
            end
            wcts_pkg::ST_INS_MUL: state_next = wcts_pkg::ST_INS_CMP;
            wcts_pkg::ST_INS_CMP:
            begin
                if (status.goes_first)
                begin
                    state_next = wcts_pkg::ST_INS_CHK;
                end
                else
                begin
                    state_next = status.last ? wcts_pkg::ST_ACC_START : wcts_pkg::ST_IDLE;
                end
            end
            wcts_pkg::ST_ACC_START: state_next = wcts_pkg::ST_ACC_CHK;
            wcts_pkg::ST_ACC_CHK:
            begin
                state_next = status.acc_done ? wcts_pkg::ST_FINISH : wcts_pkg::ST_ACC_ADD;
            end
            wcts_pkg::ST_ACC_ADD: state_next = wcts_pkg::ST_ACC_MUL;
            wcts_pkg::ST_ACC_MUL: state_next = wcts_pkg::ST_ACC_MOD;
            wcts_pkg::ST_ACC_MOD:
            begin
                if (status.mod_last)
                begin
                    state_next = wcts_pkg::ST_ACC_SUM;
                end
            end
            wcts_pkg::ST_ACC_SUM: state_next = wcts_pkg::ST_ACC_CHK;
            wcts_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = wcts_pkg::ST_IDLE;
                end
            end
            default: state_next = wcts_pkg::ST_IDLE;
        endcase
    end

    // drive commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            wcts_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            wcts_pkg::ST_INS_CHK:
            begin
                if (!status.full)
                begin
                    cmd.ins_place = status.pos_zero;
                    cmd.ins_read  = !status.pos_zero;
                end
            end
            wcts_pkg::ST_INS_MUL: cmd.ins_mul = 1'b1;
            wcts_pkg::ST_INS_CMP:
            begin
                cmd.ins_shift = status.goes_first;
                cmd.ins_place = !status.goes_first;
            end
            wcts_pkg::ST_ACC_START: cmd.acc_clear = 1'b1;
            wcts_pkg::ST_ACC_CHK: cmd.acc_read = !status.acc_done;
            wcts_pkg::ST_ACC_ADD: cmd.acc_add = 1'b1;
            wcts_pkg::ST_ACC_MUL: cmd.acc_mul = 1'b1;
            wcts_pkg::ST_ACC_MOD: cmd.acc_mod = 1'b1;
            wcts_pkg::ST_ACC_SUM: cmd.acc_sum = 1'b1;
            wcts_pkg::ST_FINISH: cmd.emit = !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[src/wcts_dp.sv]
// Datapath: sorted job memory, ratio compare, cost accumulation and modulo.
// Depends on wcts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wcts_dp (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire  [wcts_pkg::DUR_W-1:0]         duration,
    input  wire  [wcts_pkg::WGT_W-1:0]         weight,
    input  wire                                last_job,
    input  wire                                out_ready,
    output logic                               out_valid,
    output logic [wcts_pkg::COST_W-1:0]        total_cost,
    input  wcts_pkg::cmd_t                     cmd,
    output wcts_pkg::status_t                  status
);

    localparam int ENTRY_W = wcts_pkg::DUR_W + wcts_pkg::WGT_W;
    localparam int XPROD_W = wcts_pkg::DUR_W + wcts_pkg::WGT_W;

    // entries kept in descending ratio order: {weight, duration}
    logic [ENTRY_W-1:0] job_mem [wcts_pkg::MAX_JOBS];

    logic [wcts_pkg::DUR_W-1:0]     new_dur_reg;
    logic [wcts_pkg::WGT_W-1:0]     new_wgt_reg;
    logic                           new_last_reg;
    logic [wcts_pkg::COUNT_W-1:0]   count_reg;
    logic [wcts_pkg::ADDR_W-1:0]    pos_reg;
    logic [ENTRY_W-1:0]             rd_data_reg;
    logic [XPROD_W-1:0]             prod_a_reg, prod_b_reg;
    logic [wcts_pkg::COUNT_W-1:0]   k_reg;
    logic [wcts_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic [wcts_pkg::PROD_W-1:0]    rem_reg;
    logic [wcts_pkg::SHIFT_W-1:0]   shift_reg;
    logic [wcts_pkg::COST_W-1:0]    cost_reg;
    logic                           out_valid_reg;
    logic [wcts_pkg::COST_W-1:0]    out_cost_reg;

    logic [wcts_pkg::DUR_W-1:0]     rd_dur;
    logic [wcts_pkg::WGT_W-1:0]     rd_wgt;
    logic [wcts_pkg::PROD_W-1:0]    mod_step;
    logic [wcts_pkg::COST_W:0]      cost_sum;
    logic [wcts_pkg::ADDR_W-1:0]    pos_up;

    assign rd_dur   = rd_data_reg[wcts_pkg::DUR_W-1:0];
    assign rd_wgt   = rd_data_reg[ENTRY_W-1:wcts_pkg::DUR_W];
    assign mod_step = {{(wcts_pkg::PROD_W - wcts_pkg::COST_W){1'b0}}, wcts_pkg::COST_MOD}
                      << shift_reg;
    assign cost_sum = {1'b0, cost_reg} + {1'b0, rem_reg[wcts_pkg::COST_W-1:0]};
    assign pos_up   = pos_reg - 1'b1;

    assign status.full       = (count_reg == wcts_pkg::COUNT_W'(wcts_pkg::MAX_JOBS));
    assign status.last       = new_last_reg;
    assign status.pos_zero   = (pos_reg == '0);
    assign status.goes_first = (prod_a_reg > prod_b_reg);
    assign status.acc_done   = (k_reg == count_reg);
    assign status.mod_last   = (shift_reg == '0);
    assign status.out_busy   = out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign total_cost = out_cost_reg;

    // write and read the job memory
    always_ff @(posedge clk)
    begin
        if (cmd.ins_place)
        begin
            job_mem[pos_reg] <= {new_wgt_reg, new_dur_reg};
        end
        else if (cmd.ins_shift)
        begin
            job_mem[pos_reg] <= rd_data_reg;
        end
        if (cmd.ins_read)
        begin
            rd_data_reg <= job_mem[pos_up];
        end
        else if (cmd.acc_read)
        begin
            rd_data_reg <= job_mem[k_reg[wcts_pkg::ADDR_W-1:0]];
        end
    end

    // capture the job and form cross products; zero duration counts as one
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_dur_reg  <= (duration == '0) ? wcts_pkg::DUR_W'(1) : duration;
            new_wgt_reg  <= weight;
            new_last_reg <= last_job;
        end
        if (cmd.ins_mul)
        begin
            prod_a_reg <= new_wgt_reg * rd_dur;
            prod_b_reg <= rd_wgt * new_dur_reg;
        end
    end

    // track batch size and insertion point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                pos_reg <= count_reg[wcts_pkg::ADDR_W-1:0];
            end
            else if (cmd.ins_shift)
            begin
                pos_reg <= pos_up;
            end
            if (cmd.emit)
            begin
                count_reg <= '0;
            end
            else if (cmd.ins_place)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // walk sorted entries, reduce each product by shifted subtraction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            elapsed_reg <= '0;
            cost_reg    <= '0;
            shift_reg   <= '0;
        end
        else
        begin
            if (cmd.acc_clear)
            begin
                k_reg       <= '0;
                elapsed_reg <= '0;
                cost_reg    <= '0;
            end
            if (cmd.acc_add)
            begin
                elapsed_reg <= elapsed_reg + wcts_pkg::ELAPSED_W'(rd_dur);
            end
            if (cmd.acc_mul)
            begin
                shift_reg <= wcts_pkg::SHIFT_W'(wcts_pkg::SHIFT_MAX);
            end
            else if (cmd.acc_mod && shift_reg != '0)
            begin
                shift_reg <= shift_reg - 1'b1;
            end
            if (cmd.acc_sum)
            begin
                cost_reg <= (cost_sum >= {1'b0, wcts_pkg::COST_MOD})
                            ? wcts_pkg::COST_W'(cost_sum - {1'b0, wcts_pkg::COST_MOD})
                            : cost_sum[wcts_pkg::COST_W-1:0];
                k_reg    <= k_reg + 1'b1;
            end
        end
    end

    // product and remainder register
    always_ff @(posedge clk)
    begin
        if (cmd.acc_mul)
        begin
            rem_reg <= elapsed_reg * rd_wgt;
        end
        else if (cmd.acc_mod && rem_reg >= mod_step)
        begin
            rem_reg <= rem_reg - mod_step;
        end
    end

    // hold result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_cost_reg <= cost_reg;
        end
    end

endmodule
`default_nettype wire

[src/weighted_completion_time_scheduler.sv]
// Top level of the weighted completion time scheduler (Smith's rule).
// Depends on wcts_pkg, wcts_ctrl and wcts_dp.
//
// Usage:
//   Jobs enter on the s_axis channel, one transaction per job; s_axis_tlast
//   closes the batch. Each job is inserted into a ratio-ordered memory as it
//   arrives: it is compared with stored entries in turn from the end of the
//   batch until its place is found, each compare taking a read and a cross
//   product; s_axis_tready stays low until the job is placed, so a new job
//   is not taken before the last one is stored. Jobs beyond 1024 are dropped.
//   After the last job the block walks the batch (the 13-step modulo
//   reduction of each weighted completion time dominates), then loads
//   total_cost on the m_axis channel.
//   The result register parts the two sides: new jobs are taken while it
//   waits; only the next batch's result waits if m_axis_tready stays low.
//   Reset empties the batch and drops any pending result; the memory needs
//   no clearing, since only written entries are read.
`timescale 1ns / 1ps
`default_nettype none
module weighted_completion_time_scheduler (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] duration, [31:16] weight
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // [29:0] total_cost, [31:30] zero
);

    wcts_pkg::cmd_t                  cmd;
    wcts_pkg::status_t               status;
    logic [wcts_pkg::COST_W-1:0]     total_cost;

    assign m_axis_tdata = {{(32 - wcts_pkg::COST_W){1'b0}}, total_cost};

    wcts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wcts_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .duration   (s_axis_tdata[15:0]),
        .weight     (s_axis_tdata[31:16]),
        .last_job   (s_axis_tlast),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .total_cost (total_cost),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
`default_nettype wire

[src/wcts_checker.sv]
// Port-level checks for the weighted completion time scheduler, bound to the top.
// Depends on wcts_pkg and weighted_completion_time_scheduler.
`timescale 1ns / 1ps
`default_nettype none
module wcts_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // result is already reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[29:0] < wcts_pkg::COST_MOD && m_axis_tdata[31:30] == 2'b00)
        else $error("result not reduced");

    // ready is deasserted once a job is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("job taken while busy");

endmodule

bind weighted_completion_time_scheduler wcts_checker u_wcts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[verif/tb_weighted_completion_time_scheduler.sv]
// Self-checking testbench for weighted_completion_time_scheduler: streams job batches,
// predicts each batch total by ratio-ordering in the bench, and checks every result.
// Depends on wcts_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module tb_weighted_completion_time_scheduler;

    localparam int WDOG_LIMIT = 200000;

    typedef struct {
        logic [wcts_pkg::DUR_W-1:0] dur;
        logic [wcts_pkg::WGT_W-1:0] wgt;
        logic                       last;
        logic                       hold;   // wait for all results before presenting
    } job_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [15:0] duration, [31:16] weight
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [29:0] total_cost

    job_t                          job_q[$];
    job_t                          cur_job;
    logic [wcts_pkg::COST_W-1:0]   cost_q[$];
    logic [wcts_pkg::DUR_W-1:0]    batch_dur[$];
    logic [wcts_pkg::WGT_W-1:0]    batch_wgt[$];
    int               n_sent;
    int               n_err;
    int               idle_cnt;
    logic             s_acc;
    logic             stim_done;

    weighted_completion_time_scheduler uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Order the batch by weight/duration, largest first, and sum weighted completion times
    function automatic logic [wcts_pkg::COST_W-1:0] batch_cost();
        int          ord[$];
        int          pos;
        logic [63:0] t_done;
        logic [63:0] acc;
        ord = {};
        for (int i = 0; i < batch_dur.size(); i++)
        begin
            ord.push_back(i);
            pos = i;
            while (pos > 0 && 64'(batch_wgt[i]) * batch_dur[ord[pos-1]] >
                   64'(batch_wgt[ord[pos-1]]) * batch_dur[i])
            begin
                ord[pos] = ord[pos-1];
                pos--;
            end
            ord[pos] = i;
        end
        t_done = 0;
        acc = 0;
        foreach (ord[k])
        begin
            t_done += batch_dur[ord[k]];
            acc = (acc + (t_done * batch_wgt[ord[k]]) % 1000000007) % 1000000007;
        end
        return acc[wcts_pkg::COST_W-1:0];
    endfunction

    function automatic int idle_pct(input bit sender);
        if (n_sent < 180)
            return sender ? 21 : 45;
        if (n_sent < 360)
            return sender ? 45 : 21;
        return 0;
    endfunction

    // Record accepted jobs and the expected batch total
    always @(posedge clk)
    begin
        s_acc <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (batch_dur.size() < wcts_pkg::MAX_JOBS)
            begin
                batch_dur.push_back(cur_job.dur == 0 ? wcts_pkg::DUR_W'(1) : cur_job.dur);
                batch_wgt.push_back(cur_job.wgt);
            end
            if (cur_job.last)
            begin
                cost_q.push_back(batch_cost());
                batch_dur = {};
                batch_wgt = {};
            end
        end
    end

    // Drive the job stream
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_acc))
        begin
            if (job_q.size() > 0 && $urandom_range(99) >= idle_pct(1)
                && (!job_q[0].hold || cost_q.size() == 0))
            begin
                cur_job = job_q.pop_front();
                n_sent++;
                s_axis_tdata  <= {cur_job.wgt, cur_job.dur};
                s_axis_tlast  <= cur_job.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= idle_pct(0));
    end

    // Check results against the oldest expected total
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cost_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: got %0d", m_axis_tdata);
            end
            else
            begin
                if (m_axis_tdata !== {2'b00, cost_q[0]})
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("total_cost mismatch: expected %0d got %0d",
                                 cost_q[0], m_axis_tdata);
                end
                void'(cost_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_job(input int d, input int w, input bit l, input bit h = 0);
        job_t j;
        j.dur  = d[wcts_pkg::DUR_W-1:0];
        j.wgt  = w[wcts_pkg::WGT_W-1:0];
        j.last = l;
        j.hold = h;
        job_q.push_back(j);
    endtask

    initial
    begin
        int n;
        int kind;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        n_sent = 0;
        n_err = 0;
        idle_cnt = 0;
        s_acc = 1'b0;
        stim_done = 1'b0;

        // Directed: extremes, zero duration, equal ratios
        add_job(65535, 65535, 1);
        add_job(1, 0, 1);
        add_job(0, 65535, 1);
        add_job(65535, 0, 0);
        add_job(1, 65535, 0);
        add_job(0, 1, 1);
        add_job(2, 4, 0);
        add_job(1, 2, 0);
        add_job(3, 6, 0);
        add_job(5, 10, 1);
        add_job(7, 9, 0);
        add_job(1, 1000, 1);
        // Wait for every pending result before this batch
        add_job(9, 9, 1, 1);

        // Random batches, mostly short
        n = 0;
        while (n < 535)
        begin
            int len;
            len = ($urandom_range(19) == 0) ? $urandom_range(40, 25) : $urandom_range(12, 1);
            kind = $urandom_range(3);
            for (int i = 0; i < len; i++)
            begin
                int d;
                int w;
                d = $urandom_range(65535);
                w = $urandom_range(65535);
                if (kind == 1)
                begin
                    d = $urandom_range(4);
                    w = $urandom_range(8);
                end
                else if (kind == 2)
                    w = d * $urandom_range(1) ;
                add_job(d, w, i == len - 1, i == 0 && $urandom_range(15) == 0);
                n++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (job_q.size() == 0);
        @(posedge clk);
        while (s_axis_tvalid)
            @(posedge clk);
        while (cost_q.size() != 0)
            @(posedge clk);
        stim_done = 1'b1;
        repeat (200) @(posedge clk);
        if (n_err == 0 && cost_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
